/* rtl/delimiter_string_splitter_assert.svh */
// ----------------------------------------------------------------------------
// delimiter string splitter assertion macros
// shared property shapes for the splitter checks
// ----------------------------------------------------------------------------
`ifndef DELIMITER_STRING_SPLITTER_ASSERT_SVH
`define DELIMITER_STRING_SPLITTER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define DSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define DSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dss_pkg.sv */
// ----------------------------------------------------------------------------
// dss_pkg
// shared types and constants of the delimiter string splitter
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int MAX_SEP_LEN_DEF = 8;
    localparam int BYTE_W          = 8;
    localparam int SEP_W           = 64;
    localparam int LEN_W           = 4;
    localparam int CFG_IDX_W       = 1;

    // register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_LEN   = 1'b1;

    // reset values of the config registers
    localparam logic [SEP_W-1:0] SEP_BYTES_RST = 64'd32;
    localparam logic [LEN_W-1:0] SEP_LEN_RST   = 4'd1;

    // one result item as it travels down the output chain
    typedef struct packed {
        logic              valid;
        logic              last;
        logic              te;
        logic [BYTE_W-1:0] data;
    } t_res;

endpackage

/* rtl/dss_cell.sv */
// ----------------------------------------------------------------------------
// dss_cell
// one cell of the output chain: holds a result, loads or takes its neighbor
// ----------------------------------------------------------------------------
module dss_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic          i_shift,
    input  dss_pkg::t_res i_load_res,
    input  dss_pkg::t_res i_next_res,
    output dss_pkg::t_res o_res
);

    logic                       r_valid;
    logic                       r_last;
    logic                       r_te;
    logic [dss_pkg::BYTE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_load_res.valid;
        end else if (i_shift) begin
            r_valid <= i_next_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_last <= i_load_res.last;
            r_te   <= i_load_res.te;
            r_data <= i_load_res.data;
        end else if (i_shift) begin
            r_last <= i_next_res.last;
            r_te   <= i_next_res.te;
            r_data <= i_next_res.data;
        end
    end

    assign o_res = '{valid: r_valid, last: r_last, te: r_te, data: r_data};

endmodule

/* rtl/dss_match.sv */
// ----------------------------------------------------------------------------
// dss_match
// pending window and parallel separator match, builds the results of a byte
// ----------------------------------------------------------------------------
module dss_match #(
    parameter int MAX_SEP_LEN = dss_pkg::MAX_SEP_LEN_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_step,
    input  logic [dss_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_eos,
    input  logic [dss_pkg::SEP_W-1:0]  i_sep,
    input  logic [dss_pkg::LEN_W-1:0]  i_sep_len,
    output dss_pkg::t_res              o_res [MAX_SEP_LEN+1]
);

    localparam int NSLOT = MAX_SEP_LEN + 1;
    localparam int CW    = $clog2(MAX_SEP_LEN + 1);
    localparam int KW    = $clog2(MAX_SEP_LEN + 2);

    logic [CW-1:0]              r_cnt;
    logic [CW-1:0]              n_cnt;
    logic [dss_pkg::BYTE_W-1:0] r_win [MAX_SEP_LEN];
    logic [dss_pkg::BYTE_W-1:0] n_win [MAX_SEP_LEN];

    logic [dss_pkg::BYTE_W-1:0] buf_b [MAX_SEP_LEN];
    logic [dss_pkg::BYTE_W-1:0] sep_b [MAX_SEP_LEN];
    logic [CW-1:0]              len_eff;
    logic [CW-1:0]              nbuf;
    logic [CW-1:0]              sstar;
    logic [MAX_SEP_LEN-1:0]     ok;
    logic                       full;
    logic [KW-1:0]              nb;
    logic [KW-1:0]              nte;
    logic [KW-1:0]              k;

    // separator length as used: zero reads as one, clamp at the maximum
    always_comb begin
        if (i_sep_len == '0) begin
            len_eff = CW'(1);
        end else if (i_sep_len > dss_pkg::LEN_W'(MAX_SEP_LEN)) begin
            len_eff = CW'(MAX_SEP_LEN);
        end else begin
            len_eff = CW'(i_sep_len);
        end
    end

    // window plus the new byte, and separator bytes
    always_comb begin
        for (int j = 0; j < MAX_SEP_LEN; j++) begin
            sep_b[j] = i_sep[dss_pkg::BYTE_W*j +: dss_pkg::BYTE_W];
            buf_b[j] = (j < int'(r_cnt)) ? r_win[j] : i_byte;
        end
        nbuf = r_cnt + CW'(1);
    end

    // prefix test at every start position, first hit wins
    always_comb begin
        for (int s = 0; s < MAX_SEP_LEN; s++) begin
            ok[s] = 1'b1;
            for (int i = 0; i < MAX_SEP_LEN; i++) begin
                if (s + i < MAX_SEP_LEN) begin
                    if (s + i < int'(nbuf) && buf_b[s+i] != sep_b[i]) begin
                        ok[s] = 1'b0;
                    end
                end
            end
        end
        sstar = nbuf;
        for (int s = MAX_SEP_LEN - 1; s >= 0; s--) begin
            if (s < int'(nbuf) && ok[s]) begin
                sstar = CW'(s);
            end
        end
        full = ok[0] && (nbuf == len_eff);
    end

    // result counts: bytes first, then token ends
    always_comb begin
        if (full) begin
            nb  = '0;
            nte = i_eos ? KW'(2) : KW'(1);
        end else if (i_eos) begin
            nb  = KW'(nbuf);
            nte = KW'(1);
        end else begin
            nb  = KW'(sstar);
            nte = '0;
        end
        k = nb + nte;
    end

    always_comb begin
        for (int r = 0; r < NSLOT; r++) begin
            o_res[r].valid = (KW'(r) < k);
            o_res[r].te    = !(KW'(r) < nb);
            o_res[r].last  = ((KW'(r) + KW'(1)) == k);
            o_res[r].data  = '0;
            if (r < MAX_SEP_LEN) begin
                if (KW'(r) < nb) begin
                    o_res[r].data = buf_b[r];
                end
            end
        end
    end

    // undecided tail moves to the front of the window
    always_comb begin
        for (int j = 0; j < MAX_SEP_LEN; j++) begin
            n_win[j] = '0;
            for (int s = 0; s < MAX_SEP_LEN; s++) begin
                if (s + j < MAX_SEP_LEN && CW'(s) == sstar) begin
                    n_win[j] = buf_b[s+j];
                end
            end
        end
        if (full || i_eos) begin
            n_cnt = '0;
        end else begin
            n_cnt = nbuf - sstar;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_clear) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_win <= n_win;
        end
    end

endmodule

/* rtl/delimiter_string_splitter.sv */
// ----------------------------------------------------------------------------
// delimiter_string_splitter
// splits a byte stream into tokens at a configurable separator string
// ----------------------------------------------------------------------------
// usage:
//   slave channel takes one text byte per item in s_tdata, s_tlast marks the
//   last byte of a string. master channel gives token bytes in m_tdata,
//   m_tuser high for a token end (data zero), m_tlast on the final result
//   caused by one input byte. bytes that may still begin a separator wait
//   in the window and give no result until decided.
// path: an accepted byte lands in the input stage, and once the output chain
//   is free it is matched and loaded into the chain, whose head cell drives
//   the master port.
// throughput: one byte per cycle while each byte yields at most one result
//   and m_tready is high. a byte yielding k results (up to MAX_SEP_LEN + 1)
//   holds the input stage until the chain has drained to its last result.
// stall: with m_tready low the chain holds, and one more byte is still taken
//   into the input stage before s_tready drops.
// reset: synchronous, active low; window empty, separator a single space.
// config: write while idle; any write empties the window.
// ----------------------------------------------------------------------------
module delimiter_string_splitter #(
    parameter int MAX_SEP_LEN = dss_pkg::MAX_SEP_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,  // [7:0] in_byte
    input  logic                          i_s_tlast,  // end_of_string
    // master stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [7:0]                    o_m_tdata,  // [7:0] out_byte
    output logic                          o_m_tuser,  // [0] is_token_end
    output logic                          o_m_tlast,  // last_of_run
    // config write port
    input  logic                          i_cfg_we,
    input  logic [dss_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dss_pkg::SEP_W-1:0]     i_cfg_wdata
);

    localparam int NSLOT = MAX_SEP_LEN + 1;

    // config registers
    logic [dss_pkg::SEP_W-1:0] r_sep;
    logic [dss_pkg::LEN_W-1:0] r_sep_len;

    // input stage
    logic                       r_stg_valid;
    logic [dss_pkg::BYTE_W-1:0] r_stg_byte;
    logic                       r_stg_eos;

    dss_pkg::t_res load_res [NSLOT];
    dss_pkg::t_res chain    [NSLOT];
    dss_pkg::t_res next_res [NSLOT];

    logic shift;
    logic chain_free;
    logic step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep     <= dss_pkg::SEP_BYTES_RST;
            r_sep_len <= dss_pkg::SEP_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dss_pkg::CFG_SEP_BYTES: r_sep     <= i_cfg_wdata;
                dss_pkg::CFG_SEP_LEN:   r_sep_len <= i_cfg_wdata[dss_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // head cell leaves when taken
    assign shift      = chain[0].valid && i_m_tready;
    // chain is empty once this cycle's shift is done
    assign chain_free = !chain[1].valid && (!chain[0].valid || i_m_tready);
    // staged byte goes through the match and into the chain
    assign step       = r_stg_valid && chain_free;
    assign o_s_tready = !r_stg_valid || chain_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_stg_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_stg_byte <= i_s_tdata;
            r_stg_eos  <= i_s_tlast;
        end
    end

    dss_match #(
        .MAX_SEP_LEN (MAX_SEP_LEN)
    ) u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (i_cfg_we),
        .i_step    (step),
        .i_byte    (r_stg_byte),
        .i_eos     (r_stg_eos),
        .i_sep     (r_sep),
        .i_sep_len (r_sep_len),
        .o_res     (load_res)
    );

    // output chain, cell zero faces the master port
    for (genvar g = 0; g < NSLOT; g++) begin : g_cell
        if (g < NSLOT - 1) begin : g_mid
            assign next_res[g] = chain[g+1];
        end else begin : g_end
            assign next_res[g] = '0;
        end

        dss_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load     (step),
            .i_shift    (shift),
            .i_load_res (load_res[g]),
            .i_next_res (next_res[g]),
            .o_res      (chain[g])
        );
    end

    assign o_m_tvalid = chain[0].valid;
    assign o_m_tdata  = chain[0].data;
    assign o_m_tuser  = chain[0].te;
    assign o_m_tlast  = chain[0].last;

    // checks
`include "delimiter_string_splitter_assert.svh"

    `DSS_ASSERT_IMP(a_chain_packed, i_clk, i_rst_n, chain[1].valid, chain[0].valid, "chain has a gap at the head")
    `DSS_ASSERT_IMP(a_run_continues, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast, chain[1].valid, "result run ends without last mark")
    `DSS_ASSERT_NXT(a_eos_result, i_clk, i_rst_n, step && r_stg_eos, o_m_tvalid, "end of string gave no result")

endmodule

/* sim/tb_delimiter_string_splitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delimiter_string_splitter
// self-checking bench for the separator-string tokenizer
// ----------------------------------------------------------------------------
// text bytes go in through the slave stream from a queue, bursty with random
// gaps. each accepted byte runs through a bench-side splitter that keeps its
// own copy of the undecided window and the separator registers, and the token
// bytes and token ends it predicts are queued. the master stream is stalled
// on a changing pattern and every result is matched field by field against
// the oldest prediction. a short directed part covers the corner cases, then
// random phases run under several separator settings, extremes included.
// ----------------------------------------------------------------------------
module tb_delimiter_string_splitter;

    // one text byte as queued for the slave side
    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } t_text_item;

    // one predicted result: token byte or token end, plus end-of-run flag
    typedef struct packed {
        logic [7:0] ch;
        logic       te;
        logic       last;
    } t_token_item;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_s_tvalid  = 1'b0;
    logic                          o_s_tready;
    logic [7:0]                    i_s_tdata   = '0;   // [7:0] in_byte
    logic                          i_s_tlast   = 1'b0; // end_of_string
    logic                          o_m_tvalid;
    logic                          i_m_tready  = 1'b0;
    logic [7:0]                    o_m_tdata;          // [7:0] out_byte
    logic                          o_m_tuser;          // [0] is_token_end
    logic                          o_m_tlast;          // last_of_run
    logic                          i_cfg_we    = 1'b0;
    logic [dss_pkg::CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [dss_pkg::SEP_W-1:0]     i_cfg_wdata = '0;

    // bytes waiting to be sent, and results still owed by the block
    t_text_item  text_q[$];
    t_token_item token_q[$];

    // bench copy of the separator registers and the undecided window
    logic [dss_pkg::SEP_W-1:0] sep_str = dss_pkg::SEP_BYTES_RST;
    logic [dss_pkg::LEN_W-1:0] sep_len = dss_pkg::SEP_LEN_RST;
    logic [7:0]                win_bytes [0:dss_pkg::MAX_SEP_LEN_DEF-1];
    int                        win_cnt = 0;

    int          errors = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    logic [1:0]  rdy_mode = 2'd0;
    int          rdy_left = 0;
    t_token_item want;

    delimiter_string_splitter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // length in use: zero counts as one, anything past the window is clipped
    function automatic int sep_eff_len();
        if (sep_len == 0)
            return 1;
        if (sep_len > dss_pkg::MAX_SEP_LEN_DEF)
            return dss_pkg::MAX_SEP_LEN_DEF;
        return int'(sep_len);
    endfunction

    function automatic logic [7:0] sep_char(input int k);
        return sep_str[8*k +: 8];
    endfunction

    // tokenize one accepted byte and queue the results it causes
    task automatic split_byte(input logic [7:0] ch, input logic eos);
        logic [7:0]  work [0:dss_pkg::MAX_SEP_LEN_DEF];
        t_token_item outs[$];
        t_token_item t;
        int          L;
        int          n;
        int          pos;
        int          m;
        int          i;
        bit          is_prefix;
        bit          waiting;
        L = sep_eff_len();
        // a window longer than the current separator cannot all be kept
        n = (win_cnt > L - 1) ? L - 1 : win_cnt;
        for (i = 0; i < n; i++)
            work[i] = win_bytes[i];
        work[n] = ch;
        n++;
        pos = 0;
        waiting = 1'b0;
        while (pos < n && !waiting) begin
            m = n - pos;
            is_prefix = 1'b1;
            for (i = 0; i < m && i < L && is_prefix; i++)
                if (work[pos+i] != sep_char(i))
                    is_prefix = 1'b0;
            if (is_prefix && m == L) begin
                // whole separator: drop it and close the token
                outs.push_back('{ch: 8'h00, te: 1'b1, last: 1'b0});
                pos += L;
            end else if (is_prefix) begin
                // could still grow into a separator, keep undecided
                waiting = 1'b1;
            end else begin
                // this byte cannot start a match any more
                outs.push_back('{ch: work[pos], te: 1'b0, last: 1'b0});
                pos++;
            end
        end
        if (eos) begin
            // flush the window as token bytes, then the final token end
            while (pos < n) begin
                outs.push_back('{ch: work[pos], te: 1'b0, last: 1'b0});
                pos++;
            end
            outs.push_back('{ch: 8'h00, te: 1'b1, last: 1'b0});
            win_cnt = 0;
        end else begin
            win_cnt = 0;
            while (pos < n) begin
                win_bytes[win_cnt] = work[pos];
                win_cnt++;
                pos++;
            end
        end
        if (outs.size() > 0) begin
            t = outs.pop_back();
            t.last = 1'b1;
            outs.push_back(t);
        end
        for (i = 0; i < outs.size(); i++)
            token_q.push_back(outs[i]);
    endtask

    // register write; the block is idle here, any write empties the window
    task automatic write_reg(input logic [dss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dss_pkg::SEP_W-1:0]     val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == dss_pkg::CFG_SEP_BYTES)
            sep_str = val;
        else
            sep_len = val[dss_pkg::LEN_W-1:0];
        win_cnt = 0;
    endtask

    // sender drained and every result in; extra cycles cover a byte still
    // in flight that causes no result
    task automatic wait_idle();
        while (text_q.size() != 0 || i_s_tvalid || token_q.size() != 0)
            @(negedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic queue_byte(input logic [7:0] ch, input logic eos);
        text_q.push_back('{ch: ch, eos: eos});
    endtask

    // one string built mostly from separators, near misses and separator
    // characters, with some plain noise
    task automatic gen_text(input int nbytes, input bit close);
        t_text_item it;
        int         L;
        int         made;
        int         r;
        int         k;
        int         plen;
        L = sep_eff_len();
        made = 0;
        while (made < nbytes) begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
                for (k = 0; k < L; k++)
                    queue_byte(sep_char(k), 1'b0);
                made += L;
            end else if (r < 6 && L > 1) begin
                // broken separator: a true prefix, then anything
                plen = $urandom_range(1, L - 1);
                for (k = 0; k < plen; k++)
                    queue_byte(sep_char(k), 1'b0);
                queue_byte(8'($urandom_range(0, 255)), 1'b0);
                made += plen + 1;
            end else if (r < 8) begin
                queue_byte(sep_char($urandom_range(0, L - 1)), 1'b0);
                made++;
            end else begin
                queue_byte(8'($urandom_range(0, 255)), 1'b0);
                made++;
            end
        end
        if (close) begin
            it = text_q.pop_back();
            it.eos = 1'b1;
            text_q.push_back(it);
        end
    endtask

    // sender: bursts of random length, random gaps in between
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                void'(text_q.pop_front());
            if (i_s_tvalid && !o_s_tready) begin
                // held item stays on the bus
            end else if (gap_left != 0) begin
                i_s_tvalid <= 1'b0;
                gap_left   <= gap_left - 1;
            end else if (text_q.size() != 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= text_q[0].ch;
                i_s_tlast  <= text_q[0].eos;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // prediction on every accepted item
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            split_byte(i_s_tdata, i_s_tlast);
    end

    // receiver stall pattern: free run, light random, periodic, heavy stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            rdy_left   <= 0;
        end else begin
            if (rdy_left == 0) begin
                rdy_mode <= 2'($urandom_range(0, 3));
                rdy_left <= $urandom_range(8, 64);
            end else begin
                rdy_left <= rdy_left - 1;
            end
            case (rdy_mode)
                2'd0: i_m_tready <= 1'b1;
                2'd1: i_m_tready <= ($urandom_range(0, 3) != 0);
                2'd2: i_m_tready <= (rdy_left % 5 != 0);
                default: i_m_tready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // result check against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (token_q.size() == 0) begin
                $error("unexpected item: out_byte %02h is_token_end %0b last_of_run %0b",
                       o_m_tdata, o_m_tuser, o_m_tlast);
                errors++;
            end else begin
                want = token_q.pop_front();
                if (o_m_tdata !== want.ch) begin
                    $error("out_byte: expected %02h, got %02h", want.ch, o_m_tdata);
                    errors++;
                end
                if (o_m_tuser !== want.te) begin
                    $error("is_token_end: expected %0b, got %0b", want.te, o_m_tuser);
                    errors++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("last_of_run: expected %0b, got %0b", want.last, o_m_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        int                        ph;
        int                        goal;
        int                        spin;
        logic [dss_pkg::SEP_W-1:0] sep_val;
        logic [dss_pkg::SEP_W-1:0] len_val;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset separator is one space: plain byte, empty token, zero and
        // all-ones characters, separator as last byte of the string
        queue_byte("a", 1'b0);
        queue_byte(" ", 1'b0);
        queue_byte(" ", 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(" ", 1'b1);
        wait_idle();

        // "abc" with junk above the used length; leave "ab" undecided
        write_reg(dss_pkg::CFG_SEP_BYTES, 64'hA5A5_A5A5_A563_6261);
        write_reg(dss_pkg::CFG_SEP_LEN, 64'd3);
        @(negedge i_clk);
        queue_byte("x", 1'b0);
        queue_byte("a", 1'b0);
        queue_byte("b", 1'b0);
        queue_byte("c", 1'b0);
        queue_byte("a", 1'b0);
        queue_byte("b", 1'b0);
        wait_idle();

        // length zero acts as one; the write throws the pending "ab" away
        write_reg(dss_pkg::CFG_SEP_LEN, 64'd0);
        @(negedge i_clk);
        queue_byte("a", 1'b0);
        queue_byte("b", 1'b0);
        queue_byte("a", 1'b1);
        wait_idle();

        // oversized length clipped to eight; a seven-byte prefix broken by
        // the final byte gives the longest run of results
        write_reg(dss_pkg::CFG_SEP_BYTES, '1);
        write_reg(dss_pkg::CFG_SEP_LEN, 64'd15);
        @(negedge i_clk);
        repeat (7) queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b1);

        // random phases, each under its own separator setting
        for (ph = 0; ph < 9; ph++) begin
            wait_idle();
            sep_val = {$urandom, $urandom};
            len_val = 64'($urandom_range(1, 8));
            case (ph)
                0: len_val = 64'd0;
                1: len_val = 64'($urandom_range(9, 15));
                2: begin
                    sep_val = '0;
                    len_val = 64'd8;
                end
                3: begin
                    sep_val = '1;
                    len_val = 64'd8;
                end
                4: begin
                    sep_val[7:0] = 8'h00;
                    len_val = 64'd1;
                end
                5: len_val = 64'd8;
                default: ;
            endcase
            if ($urandom_range(0, 1) == 0) begin
                write_reg(dss_pkg::CFG_SEP_BYTES, sep_val);
                write_reg(dss_pkg::CFG_SEP_LEN, len_val);
            end else begin
                write_reg(dss_pkg::CFG_SEP_LEN, len_val);
                write_reg(dss_pkg::CFG_SEP_BYTES, sep_val);
            end
            @(negedge i_clk);
            // a string left open at the end of a phase tests the window drop
            goal = text_q.size() + 18;
            while (text_q.size() < goal)
                gen_text($urandom_range(1, 10), $urandom_range(0, 5) != 0);
        end

        // drain with a bound so a missing result shows up as leftover
        while (text_q.size() != 0 || i_s_tvalid)
            @(negedge i_clk);
        spin = 0;
        while (token_q.size() != 0 && spin < 4000) begin
            @(negedge i_clk);
            spin++;
        end
        repeat (16) @(posedge i_clk);
        if (token_q.size() != 0) begin
            $error("%0d expected results never arrived", token_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
